[sv/load_cell_adc_serial_reader_defines.svh]
// assertion helpers used by the asserting file
`ifndef LOAD_CELL_ADC_SERIAL_READER_DEFINES_SVH
`define LOAD_CELL_ADC_SERIAL_READER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LCSR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcsr assertion failed");

// next-cycle implication, checked out of reset
`define LCSR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcsr assertion failed");

`endif

[sv/lcsr_pkg.sv]
`default_nettype none
package lcsr_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int GAIN_W    = 2;
  localparam int HALF_W    = 8;
  localparam int TIMEOUT_W = 24;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 24;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_SELECT       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS     = 2'd2;

  // register reset values
  localparam logic [GAIN_W-1:0]    GAIN_RST    = 2'd2;
  localparam logic [HALF_W-1:0]    HALF_RST    = 8'd1;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 24'd200000;

  // largest meaningful gain code
  localparam logic [GAIN_W-1:0] GAIN_MAX = 2'd2;

  // sequencer phases
  localparam int PHASE_W = 2;
  localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
  localparam logic [PHASE_W-1:0] PH_WAIT = 2'd1;
  localparam logic [PHASE_W-1:0] PH_HIGH = 2'd2;
  localparam logic [PHASE_W-1:0] PH_LOW  = 2'd3;

  typedef struct packed {
    logic start_read;
    logic power_down;
    logic dout_level;
  } in_item_t;

  typedef struct packed {
    logic                       sck_level;
    logic                       sample_valid;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       timed_out;
    logic                       busy_res;
    logic                       device_ready;
  } out_item_t;

  typedef struct packed {
    logic [GAIN_W-1:0]    gain_select;
    logic [HALF_W-1:0]    half_period_ticks;
    logic [TIMEOUT_W-1:0] timeout_ticks;
  } cfg_t;

endpackage
`default_nettype wire

[sv/lcsr_in_if.sv]
`default_nettype none
interface lcsr_in_if;
  import lcsr_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/lcsr_out_if.sv]
`default_nettype none
interface lcsr_out_if;
  import lcsr_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/lcsr_cfg_if.sv]
`default_nettype none
interface lcsr_cfg_if;
  import lcsr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

[sv/load_cell_adc_serial_reader.sv]
// a beat accepted into the input register is stepped combinationally and written to
//   the result register once the result slot is free; that register drives the result channel
// throughput: one beat per cycle while the result side takes each result, through the
//   combinational step between input and result registers; back-pressure on the result side stalls the input side
// reset: synchronous active-low rst_n clears both stages, returns the sequencer to
//   idle and loads the registers with gain 2, half period 1, timeout 200000
`default_nettype none
`include "load_cell_adc_serial_reader_defines.svh"
module load_cell_adc_serial_reader #(
  parameter int DATA_BITS = 24
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lcsr_in_if.sink     in_ch,
  lcsr_out_if.source  out_ch,
  lcsr_cfg_if.sink    cfg_ch
);
  import lcsr_pkg::*;

  // configuration registers, always writable
  cfg_t cfg_r;

  // input stage
  logic     in_valid_r;
  in_item_t in_item_r;

  // result stage
  logic      out_valid_r;
  out_item_t out_item_r;

  out_item_t step_res;
  logic      out_free;
  logic      step_fire;

  // result slot frees when empty or being taken this cycle
  assign out_free  = !out_valid_r || out_ch.ready;
  // the held input beat moves through the step logic into the result slot
  assign step_fire = in_valid_r && out_free;

  assign in_ch.ready  = !in_valid_r || out_free;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;
  assign cfg_ch.ready = 1'b1;

  // register decode; writes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_select       <= GAIN_RST;
      cfg_r.half_period_ticks <= HALF_RST;
      cfg_r.timeout_ticks     <= TIMEOUT_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_GAIN_SELECT:       cfg_r.gain_select       <= cfg_ch.wdata[GAIN_W-1:0];
        REG_HALF_PERIOD_TICKS: cfg_r.half_period_ticks <= cfg_ch.wdata[HALF_W-1:0];
        REG_TIMEOUT_TICKS:     cfg_r.timeout_ticks     <= cfg_ch.wdata[TIMEOUT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r <= in_ch.data;
    end
  end

  // pin sequencer: one tick per beat
  lcsr_engine #(
    .DATA_BITS(DATA_BITS)
  ) u_engine (
    .clk  (clk),
    .rst_n(rst_n),
    .step (step_fire),
    .item (in_item_r),
    .cfg  (cfg_r),
    .res  (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= step_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      out_item_r <= step_res;
    end
  end

  // a finished sample and a timeout never share a tick
  `LCSR_ASSERT_NOW(a_no_sample_and_timeout, out_valid_r,
                   !(out_item_r.sample_valid && out_item_r.timed_out))
  // a read that reports leaves the sequencer idle
  `LCSR_ASSERT_NOW(a_done_not_busy,
                   out_valid_r && (out_item_r.sample_valid || out_item_r.timed_out),
                   !out_item_r.busy_res)
  // a stalled input beat stays held for the step logic
  `LCSR_ASSERT_NEXT(a_in_stage_holds, in_valid_r && !out_free,
                    in_valid_r && $stable(in_item_r))

endmodule
`default_nettype wire

[sv/lcsr_engine.sv]
`default_nettype none
module lcsr_engine #(
  parameter int DATA_BITS = 24
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step,
  input  wire lcsr_pkg::in_item_t  item,
  input  wire lcsr_pkg::cfg_t      cfg,
  output lcsr_pkg::out_item_t      res
);
  import lcsr_pkg::*;

  localparam int PC_W = $clog2(DATA_BITS + 4);

  logic [PHASE_W-1:0]   phase_r, phase_nxt;
  logic [PC_W-1:0]      pulse_r, pulse_nxt;
  logic [DATA_BITS-1:0] shift_r, shift_nxt;
  logic [HALF_W-1:0]    half_r, half_nxt;
  logic [TIMEOUT_W-1:0] wait_r, wait_nxt;
  logic                 sck_r, sck_nxt;

  logic [HALF_W-1:0]    hp;
  logic [TIMEOUT_W-1:0] to;
  logic [GAIN_W-1:0]    gs;
  logic [PC_W-1:0]      pulse_inc;
  logic [PC_W-1:0]      pulse_end;
  logic                 wait_done;
  logic                 half_done;

  // zero acts as one, gain code three acts as two
  assign hp = (cfg.half_period_ticks == '0) ? HALF_W'(1) : cfg.half_period_ticks;
  assign to = (cfg.timeout_ticks == '0) ? TIMEOUT_W'(1) : cfg.timeout_ticks;
  assign gs = (cfg.gain_select > GAIN_MAX) ? GAIN_MAX : cfg.gain_select;

  assign pulse_inc = pulse_r + PC_W'(1);
  assign pulse_end = PC_W'(DATA_BITS) + PC_W'(gs) + PC_W'(1);
  assign wait_done = ({1'b0, wait_r} + (TIMEOUT_W+1)'(1)) >= {1'b0, to};
  assign half_done = half_r >= hp;

  always_comb begin
    phase_nxt = phase_r;
    pulse_nxt = pulse_r;
    shift_nxt = shift_r;
    half_nxt  = half_r;
    wait_nxt  = wait_r;
    sck_nxt   = sck_r;
    res       = '0;

    if (item.power_down) begin
      phase_nxt = PH_IDLE;
      pulse_nxt = '0;
      half_nxt  = '0;
      wait_nxt  = '0;
      sck_nxt   = 1'b1;
    end else begin
      case (phase_r)
        PH_IDLE: begin
          sck_nxt = 1'b0;
          if (item.start_read) begin
            phase_nxt = PH_WAIT;
            wait_nxt  = '0;
          end
        end
        PH_WAIT: begin
          sck_nxt = 1'b0;
          if (!item.dout_level) begin
            phase_nxt = PH_HIGH;
            sck_nxt   = 1'b1;
            half_nxt  = HALF_W'(1);
            pulse_nxt = '0;
            shift_nxt = '0;
          end else if (wait_done) begin
            res.timed_out = 1'b1;
            phase_nxt     = PH_IDLE;
            wait_nxt      = '0;
          end else begin
            wait_nxt = wait_r + TIMEOUT_W'(1);
          end
        end
        PH_HIGH: begin
          if (half_done) begin
            // data bit sampled at the end of the high half
            if (pulse_r < PC_W'(DATA_BITS)) begin
              shift_nxt = {shift_r[DATA_BITS-2:0], item.dout_level};
            end
            sck_nxt   = 1'b0;
            phase_nxt = PH_LOW;
            half_nxt  = HALF_W'(1);
          end else begin
            half_nxt = half_r + HALF_W'(1);
          end
        end
        PH_LOW: begin
          if (half_done) begin
            pulse_nxt = pulse_inc;
            half_nxt  = HALF_W'(1);
            if (pulse_inc >= pulse_end) begin
              res.sample_valid = 1'b1;
              res.sample_value = SAMPLE_W'($signed(shift_r));
              phase_nxt        = PH_IDLE;
              pulse_nxt        = '0;
              half_nxt         = '0;
              sck_nxt          = 1'b0;
            end else begin
              phase_nxt = PH_HIGH;
              sck_nxt   = 1'b1;
            end
          end else begin
            half_nxt = half_r + HALF_W'(1);
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    res.sck_level    = sck_nxt;
    res.busy_res     = (phase_nxt != PH_IDLE);
    res.device_ready = ~item.dout_level;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pulse_r <= '0;
      shift_r <= '0;
      half_r  <= '0;
      wait_r  <= '0;
      sck_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      pulse_r <= pulse_nxt;
      shift_r <= shift_nxt;
      half_r  <= half_nxt;
      wait_r  <= wait_nxt;
      sck_r   <= sck_nxt;
    end
  end

endmodule
`default_nettype wire
